[sv/srd_pkg.sv]
package srd_pkg;

	localparam logic [7:0] START_BYTE = 8'h3E;

	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam int unsigned MOTOR_ADDR_W = 6;
	localparam logic [MOTOR_ADDR_W-1:0] MOTOR_ADDR_RESET = MOTOR_ADDR_W'(1);

	// register index, taken from the word address bits of paddr
	localparam logic REG_MOTOR_ADDRESS = 1'b0;

	typedef enum logic [0:0] {
		CMD_BYTE    = 1'b0,
		CMD_TIMEOUT = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_CMD  = 3'd1,
		PH_ADDR = 3'd2,
		PH_LEN  = 3'd3,
		PH_HSUM = 3'd4,
		PH_DATA = 3'd5,
		PH_DSUM = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_HDR_BAD    = 3'd1,
		ST_WRONG_ADDR = 3'd2,
		ST_DATA_BAD   = 3'd3,
		ST_TRUNC      = 3'd4
	} status_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic       is_frame_end;
		logic [7:0] payload_byte;
		logic [7:0] byte_index;
		logic [7:0] frame_command;
		logic [7:0] frame_length;
		status_t    status;
	} result_t;

endpackage

[sv/srd_channels.sv]
interface srd_item_if;
	logic             valid;
	logic             ready;
	srd_pkg::cmd_t    cmd;
	logic [7:0]       rx_byte;

	modport source (output valid, output cmd, output rx_byte, input ready);
	modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface srd_result_if;
	logic             valid;
	logic             ready;
	logic             is_frame_end;
	logic [7:0]       payload_byte;
	logic [7:0]       byte_index;
	logic [7:0]       frame_command;
	logic [7:0]       frame_length;
	srd_pkg::status_t status;

	modport source (output valid, output is_frame_end, output payload_byte, output byte_index,
		output frame_command, output frame_length, output status, input ready);
	modport sink   (input valid, input is_frame_end, input payload_byte, input byte_index,
		input frame_command, input frame_length, input status, output ready);
endinterface

[sv/srd_in_stage.sv]
module srd_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	srd_item_if.sink       item,
	input  logic           advance,
	output logic           valid_s1,
	output srd_pkg::item_t item_s1
);

	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.cmd     <= item.cmd;
			item_s1.rx_byte <= item.rx_byte;
		end
	end

endmodule

[sv/srd_parser.sv]
module srd_parser (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step,
	input  srd_pkg::item_t                     item_s1,
	input  logic [srd_pkg::MOTOR_ADDR_W-1:0]   motor_address,
	output logic                               has_result,
	output srd_pkg::result_t                   result
);

	srd_pkg::phase_t phase_q, phase_d;
	logic [7:0] held_command_q, held_command_d;
	logic       address_matched_q, address_matched_d;
	logic [7:0] held_length_q, held_length_d;
	logic [7:0] bytes_seen_q, bytes_seen_d;
	logic [7:0] running_sum_q, running_sum_d;

	logic [7:0] b;
	logic [7:0] sum_next;
	logic [7:0] seen_next;
	logic       is_timeout;

	assign b          = item_s1.rx_byte;
	assign sum_next   = running_sum_q + b;
	assign seen_next  = bytes_seen_q + 8'd1;
	assign is_timeout = (item_s1.cmd == srd_pkg::CMD_TIMEOUT);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (is_timeout) begin
			phase_d = srd_pkg::PH_HUNT;
		end else begin
			unique case (phase_q)
				srd_pkg::PH_HUNT: if (b == srd_pkg::START_BYTE) phase_d = srd_pkg::PH_CMD;
				srd_pkg::PH_CMD:  phase_d = srd_pkg::PH_ADDR;
				srd_pkg::PH_ADDR: phase_d = srd_pkg::PH_LEN;
				srd_pkg::PH_LEN:  phase_d = srd_pkg::PH_HSUM;
				srd_pkg::PH_HSUM: begin
					if (b != running_sum_q || held_length_q == 8'd0)
						phase_d = srd_pkg::PH_HUNT;
					else
						phase_d = srd_pkg::PH_DATA;
				end
				srd_pkg::PH_DATA: if (seen_next == held_length_q) phase_d = srd_pkg::PH_DSUM;
				srd_pkg::PH_DSUM: phase_d = srd_pkg::PH_HUNT;
				default:          phase_d = srd_pkg::PH_HUNT;
			endcase
		end
	end

	// held fields and result
	always_comb begin
		held_command_d    = held_command_q;
		address_matched_d = address_matched_q;
		held_length_d     = held_length_q;
		bytes_seen_d      = bytes_seen_q;
		running_sum_d     = running_sum_q;
		has_result           = 1'b0;
		result.is_frame_end  = 1'b1;
		result.payload_byte  = 8'd0;
		result.byte_index    = 8'd0;
		result.frame_command = held_command_q;
		result.frame_length  = held_length_q;
		result.status        = srd_pkg::ST_OK;
		if (is_timeout) begin
			has_result    = (phase_q != srd_pkg::PH_HUNT);
			result.status = srd_pkg::ST_TRUNC;
		end else begin
			unique case (phase_q)
				srd_pkg::PH_HUNT: begin
					if (b == srd_pkg::START_BYTE) begin
						held_command_d    = 8'd0;
						held_length_d     = 8'd0;
						address_matched_d = 1'b0;
						bytes_seen_d      = 8'd0;
						running_sum_d     = b;
					end
				end
				srd_pkg::PH_CMD: begin
					held_command_d = b;
					running_sum_d  = sum_next;
				end
				srd_pkg::PH_ADDR: begin
					// full address byte against the zero-extended register
					address_matched_d = (b == 8'(motor_address));
					running_sum_d     = sum_next;
				end
				srd_pkg::PH_LEN: begin
					held_length_d = b;
					running_sum_d = sum_next;
				end
				srd_pkg::PH_HSUM: begin
					if (b != running_sum_q) begin
						has_result    = 1'b1;
						result.status = srd_pkg::ST_HDR_BAD;
					end else if (held_length_q == 8'd0) begin
						has_result    = 1'b1;
						result.status = address_matched_q ? srd_pkg::ST_OK
							: srd_pkg::ST_WRONG_ADDR;
					end else begin
						running_sum_d = 8'd0;
						bytes_seen_d  = 8'd0;
					end
				end
				srd_pkg::PH_DATA: begin
					running_sum_d       = sum_next;
					bytes_seen_d        = seen_next;
					has_result          = address_matched_q;
					result.is_frame_end = 1'b0;
					result.payload_byte = b;
					result.byte_index   = bytes_seen_q;
				end
				srd_pkg::PH_DSUM: begin
					has_result = 1'b1;
					if (!address_matched_q)
						result.status = srd_pkg::ST_WRONG_ADDR;
					else if (b != running_sum_q)
						result.status = srd_pkg::ST_DATA_BAD;
					else
						result.status = srd_pkg::ST_OK;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= srd_pkg::PH_HUNT;
			held_command_q    <= 8'd0;
			address_matched_q <= 1'b0;
			held_length_q     <= 8'd0;
			bytes_seen_q      <= 8'd0;
			running_sum_q     <= 8'd0;
		end else if (step) begin
			phase_q           <= phase_d;
			held_command_q    <= held_command_d;
			address_matched_q <= address_matched_d;
			held_length_q     <= held_length_d;
			bytes_seen_q      <= bytes_seen_d;
			running_sum_q     <= running_sum_d;
		end
	end

endmodule

[sv/srd_out_stage.sv]
module srd_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  srd_pkg::result_t result_in,
	output logic             free,
	srd_result_if.source     result
);

	logic             valid_q;
	srd_pkg::result_t result_q;

	assign free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_in;
		end
	end

	assign result.valid         = valid_q;
	assign result.is_frame_end  = result_q.is_frame_end;
	assign result.payload_byte  = result_q.payload_byte;
	assign result.byte_index    = result_q.byte_index;
	assign result.frame_command = result_q.frame_command;
	assign result.frame_length  = result_q.frame_length;
	assign result.status        = result_q.status;

endmodule

[sv/servo_response_deframer.sv]
// channel   dir  beat payload
// item      in   cmd, rx_byte
// result    out  is_frame_end, payload_byte, byte_index, frame_command, frame_length, status
// apb       in   motor_address at byte address 0
//
// one byte or timeout per cycle unless the result register is held; a beat goes from item
// to result through the input register and the result register around the parser step
// a byte that yields no result never waits on the result side
// a beat that yields a result stalls only while the result register is held
// arst_n clears the parser to hunting and motor_address to 1
module servo_response_deframer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [srd_pkg::PADDR_W-1:0]  paddr,
	input  logic [srd_pkg::PDATA_W-1:0]  pwdata,
	output logic [srd_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	srd_item_if.sink                     item,
	srd_result_if.source                 result
);

	logic [srd_pkg::MOTOR_ADDR_W-1:0] motor_address_q;
	logic             valid_s1;
	srd_pkg::item_t   item_s1;
	logic             has_result;
	srd_pkg::result_t step_result;
	logic             free;
	logic             advance;
	logic             load;
	logic             sel_motor;

	assign sel_motor = (paddr[srd_pkg::PADDR_W-1] == srd_pkg::REG_MOTOR_ADDRESS);
	assign pready    = 1'b1;
	assign prdata    = sel_motor ? srd_pkg::PDATA_W'(motor_address_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_address_q <= srd_pkg::MOTOR_ADDR_RESET;
		end else if (psel && penable && pwrite && sel_motor) begin
			motor_address_q <= pwdata[srd_pkg::MOTOR_ADDR_W-1:0];
		end
	end

	assign advance = valid_s1 && (!has_result || free);
	assign load    = valid_s1 && has_result && free;

	srd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	srd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.item_s1       (item_s1),
		.motor_address (motor_address_q),
		.has_result    (has_result),
		.result        (step_result)
	);

	srd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.result_in (step_result),
		.free      (free),
		.result    (result)
	);

`ifndef NO_ASSERTIONS
	a_stall_holds_step: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready && valid_s1 && has_result) |-> !advance)
		else $error("parser stepped while its result could not be stored");

	a_accept_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> valid_s1)
		else $error("accepted beat lost before the input register");

	a_timeout_truncates: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && item_s1.cmd == srd_pkg::CMD_TIMEOUT && has_result)
		|-> (step_result.is_frame_end && step_result.status == srd_pkg::ST_TRUNC))
		else $error("timeout closed a frame without truncated status");

	a_payload_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !step_result.is_frame_end) |-> (step_result.status == srd_pkg::ST_OK))
		else $error("payload beat carries a non-zero status");
`endif

endmodule
